// ===== hdl/kphm_pkg.sv =====
// Package for the keyword perfect-hash matcher.
// Holds widths, the character weight function and the keyword ROM function.
// No dependencies.
package kphm_pkg;

	localparam int MaxLen     = 20;
	localparam int TableSlots = 282;
	localparam int CharW      = 8;
	localparam int LenW       = 5;
	localparam int HashW      = 11;
	localparam int SlotW      = 9;
	localparam int IdW        = 8;
	localparam logic [LenW-1:0] LenSat = 5'd31;

	// one keyword ROM row: valid, id, length, text (byte 0 lowest)
	typedef struct packed {
		logic                      valid;
		logic [IdW-1:0]            id;
		logic [LenW-1:0]           len;
		logic [MaxLen*CharW-1:0]   text;
	} kw_row_t;

	// result of a finished word, handed from the front end to the compare stage
	typedef struct packed {
		logic             ok;
		logic [SlotW-1:0] slot;
		logic [LenW-1:0]  len;
	} lookup_t;

	function automatic logic [8:0] char_weight(input logic [CharW-1:0] c);
		logic [8:0] w;
		w = 9'd282;
		if (c[7:6] == 2'b01) begin
			unique case (c[5:0])
				6'd2, 6'd6: w = 9'd15;
				6'd4: w = 9'd45;
				6'd7, 6'd34, 6'd35, 6'd45: w = 9'd10;
				6'd9, 6'd20, 6'd31, 6'd37, 6'd46, 6'd50, 6'd51, 6'd54, 6'd58: w = 9'd0;
				6'd12, 6'd13, 6'd55: w = 9'd25;
				6'd16, 6'd23, 6'd33, 6'd48, 6'd49: w = 9'd20;
				6'd19, 6'd21, 6'd38, 6'd41: w = 9'd40;
				6'd36: w = 9'd5;
				6'd39: w = 9'd50;
				6'd40: w = 9'd100;
				6'd44: w = 9'd35;
				6'd47: w = 9'd60;
				6'd52: w = 9'd90;
				6'd53: w = 9'd110;
				6'd56: w = 9'd30;
				6'd57: w = 9'd75;
				default: w = 9'd282;
			endcase
		end
		return w;
	endfunction

	function automatic kw_row_t mk(input int id, input string s);
		kw_row_t r;
		r = '0;
		r.valid = 1'b1;
		r.id = IdW'(id);
		r.len = LenW'(s.len());
		for (int i = 0; i < MaxLen; i++) begin
			if (i < s.len()) r.text[i*CharW +: CharW] = s[i];
		end
		return r;
	endfunction

	function automatic kw_row_t kw_rom(input logic [SlotW-1:0] a);
		kw_row_t r;
		r = '0;
		unique case (a)
			9'd2: r = mk(128, "_z");
			9'd5: r = mk(14, "_name");
			9'd6: r = mk(28, "escape");
			9'd7: r = mk(122, "setMask");
			9'd15: r = mk(119, "removeTextField");
			9'd18: r = mk(8, "_visible");
			9'd19: r = mk(113, "nextFrame");
			9'd25: r = mk(114, "createTextField");
			9'd32: r = mk(1, "_x");
			9'd36: r = mk(23, "extern");
			9'd37: r = mk(21, "_xmouse");
			9'd39: r = mk(108, "prevFrame");
			9'd40: r = mk(116, "createEmptyMovieClip");
			9'd45: r = mk(26, "isNaN");
			9'd46: r = mk(7, "_alpha");
			9'd50: r = mk(18, "_focusrect");
			9'd52: r = mk(131, "_renderflags");
			9'd58: r = mk(125, "setTextFormat");
			9'd59: r = mk(107, "play");
			9'd67: r = mk(211, "onPress");
			9'd69: r = mk(212, "onRelease");
			9'd71: r = mk(207, "onLoad");
			9'd72: r = mk(3, "_xscale");
			9'd75: r = mk(109, "removeMovieClip");
			9'd76: r = mk(213, "onReleaseOutside");
			9'd77: r = mk(2, "_y");
			9'd81: r = mk(102, "getURL");
			9'd82: r = mk(22, "_ymouse");
			9'd86: r = mk(200, "onData");
			9'd87: r = mk(203, "onEnterFrame");
			9'd88: r = mk(13, "_framesloaded");
			9'd91: r = mk(123, "getNewTextFormat");
			9'd92: r = mk(218, "onMouseWheel");
			9'd94: r = mk(110, "stop");
			9'd95: r = mk(216, "onSetFocus");
			9'd96: r = mk(209, "onMouseMove");
			9'd97: r = mk(12, "_target");
			9'd100: r = mk(129, "_xrotation");
			9'd101: r = mk(24, "setInterval");
			9'd102: r = mk(29, "Boolean");
			9'd105: r = mk(215, "onRollOver");
			9'd106: r = mk(15, "_droptarget");
			9'd107: r = mk(205, "onKeyUp");
			9'd108: r = mk(124, "getTextFormat");
			9'd109: r = mk(210, "onMouseUp");
			9'd113: r = mk(5, "_currentframe");
			9'd114: r = mk(16, "_url");
			9'd116: r = mk(208, "onMouseDown");
			9'd117: r = mk(4, "_yscale");
			9'd118: r = mk(127, "localToGlobal");
			9'd120: r = mk(202, "onDragOver");
			9'd125: r = mk(120, "swapDepths");
			9'd128: r = mk(19, "_soundbuftime");
			9'd131: r = mk(9, "_width");
			9'd133: r = mk(217, "onUnload");
			9'd137: r = mk(6, "_totalframes");
			9'd138: r = mk(27, "unescape");
			9'd139: r = mk(204, "onKeyDown");
			9'd141: r = mk(103, "gotoAndPlay");
			9'd143: r = mk(20, "_quality");
			9'd145: r = mk(130, "_yrotation");
			9'd147: r = mk(118, "hitTest");
			9'd148: r = mk(25, "clearInterval");
			9'd152: r = mk(17, "_highquality");
			9'd153: r = mk(112, "getBytesTotal");
			9'd154: r = mk(111, "getBytesLoaded");
			9'd159: r = mk(11, "_rotation");
			9'd161: r = mk(104, "gotoAndStop");
			9'd164: r = mk(126, "startDrag");
			9'd166: r = mk(206, "onKillFocus");
			9'd168: r = mk(106, "loadVariables");
			9'd174: r = mk(117, "getBounds");
			9'd178: r = mk(115, "getDepth");
			9'd186: r = mk(121, "unloadMovie");
			9'd204: r = mk(105, "loadMovie");
			9'd207: r = mk(10, "_height");
			9'd214: r = mk(214, "onRollOut");
			9'd229: r = mk(201, "onDragOut");
			9'd233: r = mk(101, "duplicateMovieClip");
			9'd281: r = mk(100, "attachMovie");
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/kphm_front.sv =====
// Front end: character buffer, length count and running hash.
// Depends on kphm_pkg.
module kphm_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   take,
	input  logic [kphm_pkg::CharW-1:0]             character,
	input  logic                                   last_char,
	output logic                                   done,
	output kphm_pkg::lookup_t                      look,
	output logic [kphm_pkg::MaxLen*kphm_pkg::CharW-1:0] word
);
	import kphm_pkg::*;

	logic [CharW-1:0] buf_q [MaxLen];
	logic [LenW-1:0]  len_q;
	logic [HashW-1:0] hash_q;
	logic [LenW-1:0]  len_n;
	logic [HashW-1:0] hash_n;
	logic [HashW-1:0] h_full;
	logic             hit_pos;

	always_comb begin
		hit_pos = (len_q == 5'd0) || (len_q == 5'd1) || (len_q == 5'd5) || (len_q == 5'd7);
		hash_n  = hit_pos ? hash_q + HashW'(char_weight(character)) : hash_q;
		len_n   = (len_q < LenSat) ? len_q + 5'd1 : LenSat;
		h_full  = hash_n + HashW'(len_n);
		for (int i = 0; i < MaxLen; i++) begin
			word[i*CharW +: CharW] = buf_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (take && len_q < LenW'(MaxLen)) buf_q[len_q[LenW-1:0]] <= character;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			hash_q <= '0;
			done   <= 1'b0;
			look   <= '0;
		end else begin
			done <= take && last_char;
			if (take) begin
				if (last_char) begin
					len_q     <= '0;
					hash_q    <= '0;
					look.len  <= len_n;
					look.slot <= h_full[SlotW-1:0];
					look.ok   <= (len_n >= 5'd2) && (len_n <= LenW'(MaxLen))
						&& (h_full <= HashW'(TableSlots - 1));
				end else begin
					len_q  <= len_n;
					hash_q <= hash_n;
				end
			end
		end
	end
endmodule

// ===== hdl/kphm_match.sv =====
// Compare stage: reads the keyword ROM row and compares word and length.
// Depends on kphm_pkg.
module kphm_match (
	input  kphm_pkg::lookup_t                          look,
	input  logic [kphm_pkg::MaxLen*kphm_pkg::CharW-1:0] word,
	output logic                                       matched,
	output logic [kphm_pkg::IdW-1:0]                   member_id,
	output logic [kphm_pkg::SlotW-1:0]                 slot
);
	import kphm_pkg::*;

	kw_row_t row;
	logic    eq;

	always_comb begin
		row = kw_rom(look.slot);
		eq  = look.ok && row.valid && (row.len == look.len);
		for (int i = 0; i < MaxLen; i++) begin
			if (LenW'(i) < look.len && row.text[i*CharW +: CharW] != word[i*CharW +: CharW])
				eq = 1'b0;
		end
		matched   = eq;
		member_id = eq ? row.id : '0;
		slot      = eq ? look.slot : '0;
	end
endmodule

// ===== hdl/keyword_perfect_hash_matcher.sv =====
// Top level of the keyword perfect-hash matcher.
// Depends on kphm_pkg, kphm_front and kphm_match.
//
// Slave channel: one beat per character, tdata = character, tlast marks the
// last character of a word. Master channel: one beat per word, issued after
// its last character: tdata bits [0] matched, [8:1] member_id, [17:9] slot.
// A character is taken whenever tready is high; a word result passes through
// the front lookup register and then the output register after its last beat.
// Throughput is one character per cycle while tready is high, with the hash add
// ahead of the front register and the ROM compare that follows it.
// Reset clears the length count, the hash and the output valid; the buffer
// holds whatever was last written and is overwritten by each new word.
// When the receiver stalls with a result in the output register, the next
// finished lookup waits in the front register and the slave channel holds
// tready low until the output register frees, so the buffered word and its
// lookup stay intact; while no lookup is waiting, characters flow.
module keyword_perfect_hash_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // character
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // matched, member_id, slot, zero fill
	output logic        m_tlast
);
	import kphm_pkg::*;

	logic              take, done;
	lookup_t           look;
	logic [MaxLen*CharW-1:0] word;
	logic              mt;
	logic [IdW-1:0]    mid;
	logic [SlotW-1:0]  msl;
	logic              free;
	logic              pend_q;

	// output register is free for a new result if empty or draining now
	assign free     = !m_tvalid || m_tready;
	// hold the slave channel while a finished lookup cannot move to the output
	assign s_tready = !((done || pend_q) && !free);
	assign take     = s_tvalid && s_tready;
	assign m_tlast  = 1'b1;

	kphm_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .character(s_tdata),
		.last_char(s_tlast), .done(done), .look(look), .word(word)
	);

	kphm_match u_match (.look(look), .word(word), .matched(mt), .member_id(mid), .slot(msl));

	// a finished lookup waits in the front register until the output is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			pend_q   <= 1'b0;
		end else begin
			if ((done || pend_q) && free) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {6'd0, msl, mid, mt};
				pend_q   <= 1'b0;
			end else begin
				if (m_tready) m_tvalid <= 1'b0;
				if (done) pend_q <= 1'b1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	a_nolast: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && !free |-> !(take && s_tlast)) else $error("lookup overwritten");
endmodule
